// ===== rtl/ptsp_pkg.sv =====
// shared types and constants for the preorder tree stream parser
`timescale 1ns / 1ps
package ptsp_pkg;

  localparam int NODE_BITS       = 20;
  localparam int MAX_DEPTH_DEF   = 1024;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHILDREN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_LIMIT   = 2'd2;

  localparam logic [4:0]  PLAYER_COUNT_RST = 5'd2;
  localparam logic [15:0] MAX_CHILDREN_RST = 16'd255;
  localparam logic [19:0] NODE_LIMIT_RST   = 20'd1000000;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_TRUNCATED = 3'd1;
  localparam logic [2:0] ST_DEPTH     = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;

  localparam logic KIND_NODE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic                 result_kind;
    logic [NODE_BITS-1:0] node_index;
    logic [NODE_BITS-1:0] parent_index;
    logic                 parent_valid;
    logic [7:0]           sibling_pos;
    logic [15:0]          edge_code;
    logic                 action_present;
    logic [15:0]          num_children;
    logic [2:0]           parse_status;
    logic                 final_result;
  } out_t;

endpackage

// ===== rtl/ptsp_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module ptsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/preorder_tree_stream_parser_core.sv =====
// preorder tree stream parser top level: byte parser, stack control and output buffer
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall   | ptsp_pkg::in_t
//  out_    | output    | out_valid/out_stall | ptsp_pkg::out_t
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// one byte is taken per cycle while no stack pop is running and the output side is
// not holding it; after a leaf node the input stalls through a check state, and each
// closed level adds a wait state for the registered stack ram read and another check,
// with no wait state when the stack empties. rst_n clears control state; stack ram contents are not cleared.
// a last byte that closes a node yields two transactions; the second waits in a
// holding register and the input stalls until it has moved to the output.
`timescale 1ns / 1ps
module preorder_tree_stream_parser_core #(
  parameter int MAX_DEPTH = ptsp_pkg::MAX_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  ptsp_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output ptsp_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ptsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ptsp_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import ptsp_pkg::*;

  localparam int DEPTH = MAX_DEPTH + 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = $clog2(MAX_DEPTH + 2);
  localparam int EW    = NODE_BITS + 32;

  localparam logic [2:0] PH_CNT_HI = 3'd0;
  localparam logic [2:0] PH_CNT_LO = 3'd1;
  localparam logic [2:0] PH_ACT_HI = 3'd2;
  localparam logic [2:0] PH_ACT_LO = 3'd3;
  localparam logic [2:0] PH_FLAG   = 3'd4;
  localparam logic [2:0] PH_RANGE  = 3'd5;
  localparam logic [2:0] PH_TAIL0  = 3'd6;

  localparam logic [1:0] CTL_RUN  = 2'd0;
  localparam logic [1:0] CTL_CHK  = 2'd1;
  localparam logic [1:0] CTL_WAIT = 2'd2;

  localparam logic [LW-1:0] LVL_FULL = LW'(MAX_DEPTH + 1);
  localparam logic [LW-1:0] LVL_MAX  = LW'(MAX_DEPTH);

  logic [4:0]           pc_r;
  logic [15:0]          maxc_r;
  logic [19:0]          lim_r;

  logic [2:0]           phase_r, phase_nxt;
  logic [1:0]           ctl_r, ctl_nxt;
  logic [7:0]           hi_r, hi_nxt;
  logic [15:0]          act_r, act_nxt;
  logic [5:0]           res_r, res_nxt;
  logic                 seen_r, seen_nxt;
  logic [2:0]           err_r, err_nxt;
  logic [LW-1:0]        lvl_r, lvl_nxt;
  logic [NODE_BITS-1:0] cnt_r, cnt_nxt;
  logic [NODE_BITS-1:0] tnode_r, tnode_nxt;
  logic [15:0]          tleft_r, tleft_nxt;
  logic [15:0]          tnext_r, tnext_nxt;

  logic                 out_v_r, pend_v_r;
  out_t                 out_r, pend_r;

  logic                 acc;
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic [EW-1:0]        wdata, rdata;
  logic [LW-1:0]        lvl_m1, lvl_m2;

  logic                 rec_node, rec_stat;
  out_t                 node_rec, stat_rec;
  logic [15:0]          count;
  logic [6:0]           granule;
  logic [4:0]           pc_c;
  logic [2:0]           status;
  logic                 out_free;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_v_r || !out_stall;
  assign in_stall  = (ctl_r != CTL_RUN) || pend_v_r || (out_v_r && out_stall);
  assign acc       = in_valid && !in_stall;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign lvl_m1 = lvl_r - LW'(1);
  assign lvl_m2 = lvl_r - LW'(2);
  assign count  = {hi_r, in_data.byte_value};

  always_comb begin
    if (pc_r == 5'd0) begin
      pc_c = 5'd1;
    end else if (pc_r > 5'd16) begin
      pc_c = 5'd16;
    end else begin
      pc_c = pc_r;
    end
    granule = {pc_c, 2'b00};
  end

  ptsp_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    phase_nxt = phase_r;
    ctl_nxt   = ctl_r;
    hi_nxt    = hi_r;
    act_nxt   = act_r;
    res_nxt   = res_r;
    seen_nxt  = seen_r;
    err_nxt   = err_r;
    lvl_nxt   = lvl_r;
    cnt_nxt   = cnt_r;
    tnode_nxt = tnode_r;
    tleft_nxt = tleft_r;
    tnext_nxt = tnext_r;
    we        = 1'b0;
    waddr     = lvl_m1[AW-1:0];
    wdata     = {tnode_r, tleft_r, tnext_r};
    raddr     = lvl_m2[AW-1:0];
    rec_node  = 1'b0;
    rec_stat  = 1'b0;
    node_rec  = '0;
    stat_rec  = '0;
    status    = ST_OK;

    unique case (ctl_r)
      CTL_CHK: begin
        if (lvl_r != '0 && tleft_r == 16'd0) begin
          lvl_nxt = lvl_m1;
          if (lvl_r != LW'(1)) begin
            ctl_nxt = CTL_WAIT;
          end
        end else begin
          phase_nxt = (lvl_r != '0) ? PH_ACT_HI : PH_FLAG;
          ctl_nxt   = CTL_RUN;
        end
      end
      CTL_WAIT: begin
        tnode_nxt = rdata[EW-1:32];
        tleft_nxt = rdata[31:16];
        tnext_nxt = rdata[15:0];
        ctl_nxt   = CTL_CHK;
      end
      default: begin
      end
    endcase

    if (acc) begin
      if (err_r == ST_OK) begin
        unique case (phase_r)
          PH_CNT_HI: begin
            hi_nxt    = in_data.byte_value;
            phase_nxt = PH_CNT_LO;
          end
          PH_CNT_LO: begin
            if (count > maxc_r) begin
              err_nxt = ST_INVALID;
            end else if (cnt_r >= lim_r) begin
              err_nxt = ST_TOO_LARGE;
            end else begin
              rec_node                 = 1'b1;
              node_rec.result_kind     = KIND_NODE;
              node_rec.node_index      = cnt_r;
              node_rec.num_children    = count;
              node_rec.final_result    = !in_data.last_byte;
              if (lvl_r != '0) begin
                node_rec.parent_index    = tnode_r;
                node_rec.parent_valid    = 1'b1;
                node_rec.sibling_pos     = 8'(tnext_r - 16'd1);
                node_rec.edge_code       = act_r;
                node_rec.action_present  = 1'b1;
              end
              cnt_nxt   = cnt_r + NODE_BITS'(1);
              phase_nxt = PH_ACT_HI;
              if (count != 16'd0 && lvl_r != LVL_FULL) begin
                we        = (lvl_r != '0);
                tnode_nxt = cnt_r;
                tleft_nxt = count;
                tnext_nxt = 16'd0;
                lvl_nxt   = lvl_r + LW'(1);
              end else begin
                ctl_nxt = CTL_CHK;
              end
            end
          end
          PH_ACT_HI: begin
            hi_nxt    = in_data.byte_value;
            phase_nxt = PH_ACT_LO;
          end
          PH_ACT_LO: begin
            act_nxt = count;
            if (lvl_r != '0) begin
              tleft_nxt = tleft_r - 16'd1;
              tnext_nxt = tnext_r + 16'd1;
            end
            if (lvl_r > LVL_MAX) begin
              err_nxt = ST_DEPTH;
            end else begin
              phase_nxt = PH_CNT_HI;
            end
          end
          PH_FLAG: begin
            if (in_data.byte_value == 8'd0) begin
              phase_nxt = PH_TAIL0;
            end else if (in_data.byte_value == 8'd1) begin
              phase_nxt = PH_RANGE;
              res_nxt   = '0;
              seen_nxt  = 1'b0;
            end else begin
              err_nxt = ST_INVALID;
            end
          end
          PH_RANGE: begin
            seen_nxt = 1'b1;
            res_nxt  = ({1'b0, res_r} + 7'd1 == granule) ? 6'd0 : res_r + 6'd1;
          end
          default: begin
            err_nxt = ST_INVALID;
          end
        endcase
      end

      if (in_data.last_byte) begin
        status = err_nxt;
        if (status == ST_OK) begin
          if (phase_nxt <= PH_FLAG) begin
            status = ST_TRUNCATED;
          end else if (phase_nxt == PH_RANGE && (!seen_nxt || res_nxt != 6'd0)) begin
            status = ST_INVALID;
          end
        end
        rec_stat              = 1'b1;
        stat_rec.result_kind  = KIND_STATUS;
        stat_rec.parse_status = status;
        stat_rec.final_result = 1'b1;
        phase_nxt = PH_CNT_HI;
        ctl_nxt   = CTL_RUN;
        hi_nxt    = '0;
        act_nxt   = '0;
        res_nxt   = '0;
        seen_nxt  = 1'b0;
        err_nxt   = ST_OK;
        lvl_nxt   = '0;
        cnt_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r     <= PLAYER_COUNT_RST;
      maxc_r   <= MAX_CHILDREN_RST;
      lim_r    <= NODE_LIMIT_RST;
      phase_r  <= PH_CNT_HI;
      ctl_r    <= CTL_RUN;
      hi_r     <= '0;
      act_r    <= '0;
      res_r    <= '0;
      seen_r   <= 1'b0;
      err_r    <= ST_OK;
      lvl_r    <= '0;
      cnt_r    <= '0;
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PLAYER_COUNT: pc_r   <= cfg_data[4:0];
          CFG_MAX_CHILDREN: maxc_r <= cfg_data[15:0];
          CFG_NODE_LIMIT:   lim_r  <= cfg_data[19:0];
          default: begin
          end
        endcase
      end
      phase_r <= phase_nxt;
      ctl_r   <= ctl_nxt;
      hi_r    <= hi_nxt;
      act_r   <= act_nxt;
      res_r   <= res_nxt;
      seen_r  <= seen_nxt;
      err_r   <= err_nxt;
      lvl_r   <= lvl_nxt;
      cnt_r   <= cnt_nxt;
      if (out_free) begin
        if (pend_v_r) begin
          out_v_r  <= 1'b1;
          pend_v_r <= 1'b0;
        end else begin
          out_v_r  <= rec_node || rec_stat;
          pend_v_r <= rec_node && rec_stat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    tnode_r <= tnode_nxt;
    tleft_r <= tleft_nxt;
    tnext_r <= tnext_nxt;
    if (out_free) begin
      if (pend_v_r) begin
        out_r <= pend_r;
      end else if (rec_node) begin
        out_r  <= node_rec;
        pend_r <= stat_rec;
      end else begin
        out_r <= stat_rec;
      end
    end
  end

endmodule
